// ===== hdl/rpchp_pkg.sv =====
// rpchp_pkg: types, codes and constants of the rpc call header parser
// no dependencies; used by every other file of the block
`default_nettype none

package rpchp_pkg;

    // field widths
    localparam int WORD_W     = 32;
    localparam int KIND_W     = 4;
    localparam int VB_W       = 3;
    localparam int STAT_W     = 3;
    localparam int MAX_AUTH_W = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // protocol constants and register reset values
    localparam int                    AUTH_BYTES_CAP_DEF = 400;
    localparam logic [MAX_AUTH_W-1:0] AUTH_LIMIT_RST     = 9'd400;
    localparam logic [WORD_W-1:0]     RPC_VERS_RST       = 32'd2;
    localparam logic [WORD_W-1:0]     CALL               = 32'd0;
    localparam logic [VB_W-1:0]       UNIT_BYTES         = 3'd4;

    // entries of the queue between parser and output stage
    localparam int QUEUE_DEPTH = 2;

    // field kinds, also the parse phase
    typedef enum logic [KIND_W-1:0] {
        K_XID     = 4'd0,
        K_DIR     = 4'd1,
        K_RPCVERS = 4'd2,
        K_PROG    = 4'd3,
        K_VERS    = 4'd4,
        K_PROC    = 4'd5,
        K_CFLAV   = 4'd6,
        K_CLEN    = 4'd7,
        K_CBODY   = 4'd8,
        K_VFLAV   = 4'd9,
        K_VLEN    = 4'd10,
        K_VBODY   = 4'd11
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_BUSY     = 3'd0,
        ST_DONE     = 3'd1,
        ST_NOTCALL  = 3'd2,
        ST_BADVERS  = 3'd3,
        ST_AUTHLONG = 3'd4,
        ST_DISCARD  = 3'd5
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AUTH_LIMIT           = 1'd0,
        CFG_EXPECTED_RPC_VERSION = 1'd1
    } t_cfg_index;

    // one labelled word
    typedef struct packed {
        t_kind             kind;
        logic [WORD_W-1:0] value;
        logic [VB_W-1:0]   valid_bytes;
        t_status           status;
        logic              last;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/rpchp_in_if.sv =====
// rpchp_in_if: input word channel of the rpc call header parser
// depends on rpchp_pkg for field widths
`default_nettype none

interface rpchp_in_if;
    logic                           valid;
    logic                           ready;
    logic [rpchp_pkg::WORD_W-1:0]   word;
    logic                           start_of_message;

    modport source (output valid, output word, output start_of_message, input ready);
    modport sink   (input valid, input word, input start_of_message, output ready);
endinterface

`default_nettype wire

// ===== hdl/rpchp_out_if.sv =====
// rpchp_out_if: labelled field channel of the rpc call header parser
// depends on rpchp_pkg for field widths
`default_nettype none

interface rpchp_out_if;
    logic                           valid;
    logic                           ready;
    logic [rpchp_pkg::KIND_W-1:0]   field_kind;
    logic [rpchp_pkg::WORD_W-1:0]   field_value;
    logic [rpchp_pkg::VB_W-1:0]     valid_bytes;
    logic [rpchp_pkg::STAT_W-1:0]   status;
    logic                           last;

    modport source (output valid, output field_kind, output field_value,
                    output valid_bytes, output status, output last, input ready);
    modport sink   (input valid, input field_kind, input field_value,
                    input valid_bytes, input status, input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/rpchp_front.sv =====
// rpchp_front: accepts words, tracks the parse phase and labels each word
// depends on rpchp_pkg and rpchp_in_if
`default_nettype none

module rpchp_front #(
    parameter int AUTH_BYTES_CAP = rpchp_pkg::AUTH_BYTES_CAP_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rpchp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rpchp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rpchp_in_if.sink                         i_in,
    input  logic                             i_q_ready,
    output logic                             o_q_push,
    output rpchp_pkg::t_result               o_q_data
);
    import rpchp_pkg::*;

    localparam int CAP_W = $clog2(AUTH_BYTES_CAP + 1);
    // a body length never exceeds the smaller of the register range and the cap
    localparam int LEN_W = (CAP_W < MAX_AUTH_W) ? CAP_W : MAX_AUTH_W;
    localparam logic [WORD_W-1:0] CAP_WORD = WORD_W'(AUTH_BYTES_CAP);

    logic [MAX_AUTH_W-1:0] r_max_auth;
    logic [WORD_W-1:0]     r_exp_vers;
    t_kind                 r_phase, n_phase;
    logic [LEN_W-1:0]      r_bytes, n_bytes;
    logic                  r_disc, n_disc;

    logic                  w_accept;
    logic [WORD_W-1:0]     w_word;
    logic [WORD_W-1:0]     w_max_ext;
    logic [WORD_W-1:0]     w_limit;
    t_kind                 w_phase;
    logic [LEN_W-1:0]      w_bytes;
    logic                  w_disc;
    logic [VB_W-1:0]       w_vb;
    logic [LEN_W-1:0]      w_left;
    t_result               w_res;

    assign w_accept  = i_in.valid && i_q_ready;
    assign i_in.ready = i_q_ready;
    assign w_word    = i_in.word;

    // auth length limit saturated at the cap
    assign w_max_ext = WORD_W'(r_max_auth);
    assign w_limit   = (w_max_ext > CAP_WORD) ? CAP_WORD : w_max_ext;

    // start of message restarts the parse
    assign w_phase = i_in.start_of_message ? K_XID : r_phase;
    assign w_bytes = i_in.start_of_message ? '0 : r_bytes;
    assign w_disc  = i_in.start_of_message ? 1'b0 : r_disc;

    // body byte accounting
    assign w_vb   = (w_bytes < LEN_W'(UNIT_BYTES)) ? VB_W'(w_bytes)
                                                   : UNIT_BYTES;
    assign w_left = w_bytes - LEN_W'(w_vb);

    // phase update and labelling
    always_comb begin
        n_phase = w_phase;
        n_bytes = w_bytes;
        n_disc  = w_disc;
        w_res.kind        = w_phase;
        w_res.value       = w_word;
        w_res.valid_bytes = UNIT_BYTES;
        w_res.status      = ST_BUSY;
        w_res.last        = 1'b0;
        if (w_disc || (w_phase > K_VBODY)) begin
            n_disc            = 1'b1;
            w_res.kind        = K_XID;
            w_res.valid_bytes = '0;
            w_res.status      = ST_DISCARD;
        end else begin
            case (w_phase)
                K_DIR: begin
                    if (w_word != CALL) begin
                        n_disc       = 1'b1;
                        w_res.status = ST_NOTCALL;
                        w_res.last   = 1'b1;
                    end else begin
                        n_phase = K_RPCVERS;
                    end
                end
                K_RPCVERS: begin
                    if (w_word != r_exp_vers) begin
                        n_disc       = 1'b1;
                        w_res.status = ST_BADVERS;
                        w_res.last   = 1'b1;
                    end else begin
                        n_phase = K_PROG;
                    end
                end
                K_CLEN, K_VLEN: begin
                    if (w_word > w_limit) begin
                        n_disc       = 1'b1;
                        w_res.status = ST_AUTHLONG;
                        w_res.last   = 1'b1;
                    end else begin
                        n_bytes = w_word[LEN_W-1:0];
                        if (w_word != '0) begin
                            n_phase = (w_phase == K_CLEN) ? K_CBODY : K_VBODY;
                        end else if (w_phase == K_CLEN) begin
                            n_phase = K_VFLAV;
                        end else begin
                            // empty verifier ends the header here
                            n_disc       = 1'b1;
                            n_phase      = K_XID;
                            w_res.status = ST_DONE;
                            w_res.last   = 1'b1;
                        end
                    end
                end
                K_CBODY, K_VBODY: begin
                    n_bytes           = w_left;
                    w_res.valid_bytes = w_vb;
                    if (w_left == '0) begin
                        if (w_phase == K_CBODY) begin
                            n_phase = K_VFLAV;
                        end else begin
                            n_disc       = 1'b1;
                            n_phase      = K_XID;
                            w_res.status = ST_DONE;
                            w_res.last   = 1'b1;
                        end
                    end
                end
                default: begin
                    n_phase = t_kind'(KIND_W'(w_phase) + KIND_W'(1));
                end
            endcase
        end
    end

    assign o_q_push = w_accept;
    assign o_q_data = w_res;

    // parse state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= K_XID;
            r_bytes    <= '0;
            r_disc     <= 1'b0;
            r_max_auth <= AUTH_LIMIT_RST;
            r_exp_vers <= RPC_VERS_RST;
        end else begin
            if (w_accept) begin
                r_phase <= n_phase;
                r_bytes <= n_bytes;
                r_disc  <= n_disc;
            end
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_AUTH_LIMIT:           r_max_auth <= i_cfg_data[MAX_AUTH_W-1:0];
                    CFG_EXPECTED_RPC_VERSION: r_exp_vers <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

`ifndef NO_ASSERTIONS
    // the phase never runs past the verifier body
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= K_VBODY)
        else $error("parse phase out of range");

    // a body phase always has bytes still to come
    a_body_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == K_CBODY || r_phase == K_VBODY) |-> (r_bytes != '0))
        else $error("body phase with no bytes left");

    // a word that ends the header leaves the parser discarding
    a_last_disc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_res.last) |=> r_disc)
        else $error("header end without discard");
`endif

endmodule

`default_nettype wire

// ===== hdl/rpchp_queue.sv =====
// rpchp_queue: short register queue between the parser and the output stage
// depends on rpchp_pkg for the result type
`default_nettype none

module rpchp_queue #(
    parameter int DEPTH = rpchp_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  rpchp_pkg::t_result i_data,
    output logic               o_ready,
    input  logic               i_pop,
    output logic               o_valid,
    output rpchp_pkg::t_result o_data
);
    import rpchp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_result          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    assign o_ready = (r_count != CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("queue count did not grow on push");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("queue count did not shrink on pop");
`endif

endmodule

`default_nettype wire

// ===== hdl/rpchp_back.sv =====
// rpchp_back: output register stage driving the labelled field channel
// depends on rpchp_pkg and rpchp_out_if
`default_nettype none

module rpchp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  rpchp_pkg::t_result i_q_data,
    output logic               o_q_pop,
    rpchp_out_if.source        o_out
);
    import rpchp_pkg::*;

    logic    r_valid;
    t_result r_data;

    // refill whenever the stage is empty or its transfer completes
    assign o_q_pop = i_q_valid && (!r_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || o_out.ready) begin
            r_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_data <= i_q_data;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.field_kind  = KIND_W'(r_data.kind);
    assign o_out.field_value = r_data.value;
    assign o_out.valid_bytes = r_data.valid_bytes;
    assign o_out.status      = STAT_W'(r_data.status);
    assign o_out.last        = r_data.last;

endmodule

`default_nettype wire

// ===== hdl/rpc_call_header_parser.sv =====
// rpc_call_header_parser: top level, parser front, queue and output stage
// depends on rpchp_pkg, rpchp_in_if, rpchp_out_if, rpchp_front, rpchp_queue, rpchp_back
`default_nettype none

// Parses an ONC RPC call header from 32-bit XDR words and labels each word
// with its field kind, value, valid body bytes, status and a last flag on the
// word that completes or aborts the header; later words are reported as
// discarded until the next start-of-message. One word is taken every clock
// cycle while the output keeps up, set by the phase update in the parser
// front; a word is written into the two-entry queue at its transfer and moves
// from there into the output register once that register is empty or its
// transfer completes, and is offered on the output from that register. When the
// output stalls, the queue and output register fill and the input stalls. The
// auth limit in use is saturated at AUTH_BYTES_CAP. Configuration writes take
// effect the cycle after i_cfg_we and must be done while no words are in flight.
module rpc_call_header_parser #(
    parameter int AUTH_BYTES_CAP = rpchp_pkg::AUTH_BYTES_CAP_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rpchp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rpchp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rpchp_in_if.sink                         i_in,
    rpchp_out_if.source                      o_out
);
    import rpchp_pkg::*;

    logic    w_push, w_q_ready, w_q_valid, w_pop;
    t_result w_push_data, w_pop_data;

    // word parser
    rpchp_front #(
        .AUTH_BYTES_CAP (AUTH_BYTES_CAP)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_q_ready   (w_q_ready),
        .o_q_push    (w_push),
        .o_q_data    (w_push_data)
    );

    // decoupling queue
    rpchp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_pop_data)
    );

    // output stage
    rpchp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_pop_data),
        .o_q_pop   (w_pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire
